### sv/pla_pkg.sv
// Package for the piecewise-linear temperature-to-angle block.
// Breakpoint table, field widths and region codes; no dependencies.
`default_nettype none

package pla_pkg;

    // Field widths of the two channels
    localparam int TEMP_W   = 13;
    localparam int ANGLE_W  = 12;
    localparam int REGION_W = 2;

    // Breakpoint table in whole degrees (temperature, angle)
    localparam int TABLE_SIZE = 9;
    localparam int BP_TEMP  [TABLE_SIZE] = '{12, 50, 75, 100, 110, 120, 130, 140, 150};
    localparam int BP_ANGLE [TABLE_SIZE] = '{130, 110, 97, 78, 66, 52, 41, 35, 30};
    localparam int ANGLE_MAX = 130;

    // Segment index: 0 .. TABLE_SIZE
    localparam int SEG_W = $clog2(TABLE_SIZE + 1);
    localparam int SEG_N = 2 ** SEG_W;

    // Integer bits of the table's spans and values
    localparam int DT_BITS        = 6;  // largest temperature span is 38
    localparam int DA_BITS        = 5;  // largest angle drop is 20
    localparam int ANGLE_INT_BITS = 8;  // angles up to 130
    localparam int TEMP_INT_BITS  = 9;  // signed, breakpoints up to 150

    typedef enum logic [REGION_W-1:0] {
        REGION_BELOW = 2'd0,
        REGION_INNER = 2'd1,
        REGION_ABOVE = 2'd2
    } region_t;

endpackage

`default_nettype wire

### sv/pla_temp_if.sv
// Input channel carrying one temperature sample per transfer.
// Depends on pla_pkg for the field width.
`default_nettype none

interface pla_temp_if;
    logic                               valid;
    logic                               ready;
    logic signed [pla_pkg::TEMP_W-1:0]  temp_sample;

    modport source (output valid, output temp_sample, input ready);
    modport sink   (input valid, input temp_sample, output ready);
endinterface

`default_nettype wire

### sv/pla_angle_if.sv
// Output channel carrying one gauge angle and region code per transfer.
// Depends on pla_pkg for the field widths.
`default_nettype none

interface pla_angle_if;
    logic                           valid;
    logic                           ready;
    logic [pla_pkg::ANGLE_W-1:0]    angle_out;
    logic [pla_pkg::REGION_W-1:0]   region;

    modport source (output valid, output angle_out, output region, input ready);
    modport sink   (input valid, input angle_out, input region, output ready);
endinterface

`default_nettype wire

### sv/piecewise_linear_temp_to_angle_top.sv
// Piecewise-linear temperature-to-gauge-angle mapping, five-stage pipeline.
// Throughput: one sample per cycle while not stalled; the
// whole pipeline holds while the output register is full and not taken.
// Reset (rst_n, asynchronous, active low) clears all stage valid bits.
// Depends on pla_pkg, pla_temp_if, pla_angle_if, pla_seg and pla_div.
`default_nettype none

module piecewise_linear_temp_to_angle_top #(
    parameter int TABLE_POINTS = 9,
    parameter int FRAC_BITS    = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    pla_temp_if.sink        sample,
    pla_angle_if.source     result
);
    import pla_pkg::*;

    localparam int OFFS_W = FRAC_BITS + DT_BITS;
    localparam int M_W    = OFFS_W + DA_BITS + 1;
    localparam int R_W    = M_W + DT_BITS;
    localparam int ANG_W  = FRAC_BITS + ANGLE_INT_BITS;
    localparam int POINTS = (TABLE_POINTS < TABLE_SIZE) ? TABLE_POINTS : TABLE_SIZE;

    // Pipeline advances whenever the output register is free or being taken
    logic en;
    logic v5_reg;

    assign en           = !v5_reg || result.ready;
    assign sample.ready = en;

    // Stages 1-2
    logic               seg_valid;
    logic [OFFS_W-1:0]  offs;
    logic [DA_BITS-1:0] da_mag;
    logic [DT_BITS-1:0] dt_m1;
    logic [R_W-1:0]     recip;
    logic [ANG_W-1:0]   base;
    region_t            seg_region;

    pla_seg #(
        .TABLE_POINTS (TABLE_POINTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_seg (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample.valid),
        .temp      (sample.temp_sample),
        .seg_valid (seg_valid),
        .offs      (offs),
        .da_mag    (da_mag),
        .dt_m1     (dt_m1),
        .recip     (recip),
        .base      (base),
        .region    (seg_region)
    );

    // Stages 3-4
    logic               div_valid;
    logic [ANG_W-1:0]   drop;
    logic [ANG_W-1:0]   div_base;
    region_t            div_region;

    pla_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .seg_valid  (seg_valid),
        .offs       (offs),
        .da_mag     (da_mag),
        .dt_m1      (dt_m1),
        .recip      (recip),
        .base       (base),
        .region     (seg_region),
        .div_valid  (div_valid),
        .drop       (drop),
        .div_base   (div_base),
        .div_region (div_region)
    );

    // Stage 5: subtract, clamp to 0..ANGLE_MAX, output register
    localparam logic [ANG_W-1:0] AMAX = ANG_W'(ANGLE_MAX * (1 << FRAC_BITS));

    logic signed [ANG_W:0]  angle_diff;
    logic [ANG_W-1:0]       angle_next;
    logic [ANG_W-1:0]       angle_reg;
    region_t                region_reg;

    assign angle_diff = signed'({1'b0, div_base}) - signed'({1'b0, drop});

    always_comb
    begin
        if (angle_diff < 0)
        begin
            angle_next = '0;
        end
        else if (angle_diff[ANG_W-1:0] > AMAX)
        begin
            angle_next = AMAX;
        end
        else
        begin
            angle_next = angle_diff[ANG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg  <= angle_next;
            region_reg <= div_region;
        end
    end

    assign result.valid     = v5_reg;
    assign result.angle_out = ANGLE_W'(angle_reg);
    assign result.region    = region_reg;

    // Checks
    localparam logic [ANGLE_W-1:0] FIRST_ANGLE =
        ANGLE_W'(BP_ANGLE[0] * (1 << FRAC_BITS));
    localparam logic [ANGLE_W-1:0] LAST_ANGLE =
        ANGLE_W'(BP_ANGLE[POINTS-1] * (1 << FRAC_BITS));

    // A result waiting for the sink stays put
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=>
            result.valid && $stable(result.angle_out) && $stable(result.region))
        else $error("waiting result changed");

    // A stalled pipeline keeps its occupancy
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable({seg_valid, div_valid, v5_reg}))
        else $error("pipeline moved while stalled");

    // Below-table results carry the first angle
    a_below_angle: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.region == REGION_BELOW) |-> result.angle_out == FIRST_ANGLE)
        else $error("below-table angle wrong");

    // Above-table results carry the last angle
    a_above_angle: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.region == REGION_ABOVE) |-> result.angle_out == LAST_ANGLE)
        else $error("above-table angle wrong");

endmodule

`default_nettype wire

### sv/pla_seg.sv
// Stages 1 and 2: breakpoint search and segment set-up (offset, slope terms).
// Depends on pla_pkg.
`default_nettype none

module pla_seg #(
    parameter int TABLE_POINTS = 9,
    parameter int FRAC_BITS    = 4
) (
    input  wire logic                                           clk,
    input  wire logic                                           rst_n,
    input  wire logic                                           en,
    input  wire logic                                           in_valid,
    input  wire logic signed [pla_pkg::TEMP_W-1:0]              temp,
    output logic                                                seg_valid,
    output logic [FRAC_BITS+pla_pkg::DT_BITS-1:0]               offs,
    output logic [pla_pkg::DA_BITS-1:0]                         da_mag,
    output logic [pla_pkg::DT_BITS-1:0]                         dt_m1,
    output logic [FRAC_BITS+2*pla_pkg::DT_BITS+pla_pkg::DA_BITS:0] recip,
    output logic [FRAC_BITS+pla_pkg::ANGLE_INT_BITS-1:0]        base,
    output pla_pkg::region_t                                    region
);
    import pla_pkg::*;

    localparam int POINTS = (TABLE_POINTS < TABLE_SIZE) ? TABLE_POINTS : TABLE_SIZE;
    localparam int BPT_W  = TEMP_INT_BITS + FRAC_BITS;
    localparam int CMP_W  = ((TEMP_W > BPT_W) ? TEMP_W : BPT_W) + 1;
    localparam int OFFS_W = FRAC_BITS + DT_BITS;
    localparam int M_W    = OFFS_W + DA_BITS + 1;
    localparam int K      = M_W + DT_BITS;
    localparam int R_W    = K;
    localparam int ANG_W  = FRAC_BITS + ANGLE_INT_BITS;

    // Constant tables, scaled to the fixed-point format
    logic signed [BPT_W-1:0]   bps      [SEG_N];
    logic [ANG_W-1:0]          base_tab [SEG_N];
    logic [R_W-1:0]            recip_tab[SEG_N];
    logic [DT_BITS-1:0]        dtm1_tab [SEG_N];
    logic [DA_BITS-1:0]        da_tab   [SEG_N];

    for (genvar i = 0; i < SEG_N; i++) begin : g_tab
        if (i < TABLE_SIZE) begin : g_pt
            assign bps[i]      = BPT_W'(BP_TEMP[i] * (1 << FRAC_BITS));
            assign base_tab[i] = ANG_W'(BP_ANGLE[i] * (1 << FRAC_BITS));
        end else begin : g_nopt
            assign bps[i]      = '0;
            assign base_tab[i] = '0;
        end
        if (i >= 1 && i < TABLE_SIZE) begin : g_sp
            localparam int     DT    = BP_TEMP[i] - BP_TEMP[i-1];
            // ceil(2^K / DT): exact floor division for all numerators below 2^M_W
            localparam longint RECIP = ((longint'(1) << K) + longint'(DT) - 1) / DT;
            assign recip_tab[i] = R_W'(RECIP);
            assign dtm1_tab[i]  = DT_BITS'(DT - 1);
            assign da_tab[i]    = DA_BITS'(BP_ANGLE[i-1] - BP_ANGLE[i]);
        end else begin : g_nosp
            assign recip_tab[i] = '0;
            assign dtm1_tab[i]  = '0;
            assign da_tab[i]    = '0;
        end
    end

    // Stage 1: count breakpoints at or below the sample
    logic signed [TEMP_W-1:0]  t_reg;
    logic [SEG_W-1:0]          n_reg, n_next;
    logic                      v1_reg;

    always_comb
    begin
        n_next = '0;
        for (int i = 0; i < POINTS; i++)
        begin
            if (CMP_W'(temp) >= CMP_W'(bps[i]))
            begin
                n_next = SEG_W'(i + 1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg <= temp;
            n_reg <= n_next;
        end
    end

    // Stage 2: pick segment, offset into it and slope terms
    logic [SEG_W-1:0]          lo;
    logic signed [CMP_W-1:0]   diff;
    logic [OFFS_W-1:0]         offs_next, offs_reg;
    logic [DA_BITS-1:0]        da_next, da_reg;
    logic [DT_BITS-1:0]        dtm1_next, dtm1_reg;
    logic [R_W-1:0]            recip_next, recip_reg;
    logic [ANG_W-1:0]          base_next, base_reg;
    region_t                   region_next, region_reg;
    logic                      v2_reg;

    assign lo   = n_reg - SEG_W'(1);
    assign diff = CMP_W'(t_reg) - CMP_W'(bps[lo]);

    // Edge regions use a zero offset so the later divide yields zero
    always_comb
    begin
        offs_next   = '0;
        da_next     = '0;
        dtm1_next   = '0;
        recip_next  = '0;
        base_next   = base_tab[0];
        region_next = REGION_BELOW;
        if (n_reg == '0)
        begin
            base_next   = base_tab[0];
            region_next = REGION_BELOW;
        end
        else if (n_reg >= SEG_W'(POINTS))
        begin
            base_next   = base_tab[POINTS-1];
            region_next = REGION_ABOVE;
        end
        else
        begin
            offs_next   = diff[OFFS_W-1:0];
            da_next     = da_tab[n_reg];
            dtm1_next   = dtm1_tab[n_reg];
            recip_next  = recip_tab[n_reg];
            base_next   = base_tab[lo];
            region_next = REGION_INNER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            offs_reg   <= offs_next;
            da_reg     <= da_next;
            dtm1_reg   <= dtm1_next;
            recip_reg  <= recip_next;
            base_reg   <= base_next;
            region_reg <= region_next;
        end
    end

    assign seg_valid = v2_reg;
    assign offs      = offs_reg;
    assign da_mag    = da_reg;
    assign dt_m1     = dtm1_reg;
    assign recip     = recip_reg;
    assign base      = base_reg;
    assign region    = region_reg;

endmodule

`default_nettype wire

### sv/pla_div.sv
// Stages 3 and 4: offset times angle drop, then ceiling divide by the span
// through a reciprocal multiply. Depends on pla_pkg.
`default_nettype none

module pla_div #(
    parameter int FRAC_BITS = 4
) (
    input  wire logic                                               clk,
    input  wire logic                                               rst_n,
    input  wire logic                                               en,
    input  wire logic                                               seg_valid,
    input  wire logic [FRAC_BITS+pla_pkg::DT_BITS-1:0]              offs,
    input  wire logic [pla_pkg::DA_BITS-1:0]                        da_mag,
    input  wire logic [pla_pkg::DT_BITS-1:0]                        dt_m1,
    input  wire logic [FRAC_BITS+2*pla_pkg::DT_BITS+pla_pkg::DA_BITS:0] recip,
    input  wire logic [FRAC_BITS+pla_pkg::ANGLE_INT_BITS-1:0]       base,
    input  wire pla_pkg::region_t                                   region,
    output logic                                                    div_valid,
    output logic [FRAC_BITS+pla_pkg::ANGLE_INT_BITS-1:0]            drop,
    output logic [FRAC_BITS+pla_pkg::ANGLE_INT_BITS-1:0]            div_base,
    output pla_pkg::region_t                                        div_region
);
    import pla_pkg::*;

    localparam int OFFS_W = FRAC_BITS + DT_BITS;
    localparam int M_W    = OFFS_W + DA_BITS + 1;
    localparam int K      = M_W + DT_BITS;
    localparam int R_W    = K;
    localparam int ANG_W  = FRAC_BITS + ANGLE_INT_BITS;

    // Stage 3: numerator of the ceiling divide, offs*|da| + dt - 1
    logic [M_W-1:0]     m_next, m_reg;
    logic [R_W-1:0]     recip_reg;
    logic [ANG_W-1:0]   base3_reg;
    region_t            region3_reg;
    logic               v3_reg;

    assign m_next = M_W'(offs) * M_W'(da_mag) + M_W'(dt_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= seg_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg       <= m_next;
            recip_reg   <= recip;
            base3_reg   <= base;
            region3_reg <= region;
        end
    end

    // Stage 4: quotient by reciprocal multiply and shift
    logic [M_W+R_W-1:0] prod;
    logic [ANG_W-1:0]   q_reg;
    logic [ANG_W-1:0]   base4_reg;
    region_t            region4_reg;
    logic               v4_reg;

    assign prod = (M_W+R_W)'(m_reg) * (M_W+R_W)'(recip_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_reg       <= prod[K +: ANG_W];
            base4_reg   <= base3_reg;
            region4_reg <= region3_reg;
        end
    end

    assign div_valid  = v4_reg;
    assign drop       = q_reg;
    assign div_base   = base4_reg;
    assign div_region = region4_reg;

endmodule

`default_nettype wire
